@@ sv/distance_vector_router_assert.svh @@
// ----------------------------------------------------------------------------
// Distance vector router assertion macros
// Shorthand for the concurrent checks of the router top level.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTER_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTER_ASSERT_SVH

// property holds at every edge outside reset
`define DVR_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("distance_vector_router: check failed");

// consequence holds in the cycle after the antecedent
`define DVR_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("distance_vector_router: check failed");

`endif

@@ sv/dvr_pkg.sv @@
// ----------------------------------------------------------------------------
// Distance vector router package
// Sizes, command codes and transaction types shared by the router files.
// ----------------------------------------------------------------------------
package dvr_pkg;

    localparam int NODES     = 8;
    localparam int NODE_W    = 3;
    localparam int DIST_W    = 10;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int TBL_DEPTH = 1 << ADDR_W;
    localparam int CFG_W     = 2;

    localparam logic [DIST_W-1:0] INF_RESET = 10'd1023;

    typedef enum logic [1:0] {
        CMD_ELEM      = 2'd0,
        CMD_COST_CHG  = 2'd1,
        CMD_COST_INIT = 2'd2,
        CMD_ANNOUNCE  = 2'd3
    } cmd_t;

    localparam logic [CFG_W-1:0] CFG_OWN_ID   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_INFINITY = 2'd1;
    localparam logic [CFG_W-1:0] CFG_POISON   = 2'd2;

    typedef struct packed {
        cmd_t              cmd;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] node_index;
        logic [DIST_W-1:0] distance_value;
        logic              last_element;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] dest_router;
        logic [NODE_W-1:0] entry_index;
        logic [DIST_W-1:0] distance;
        logic              packet_end;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DIST_W-1:0] data;
    } tbl_wr_t;

endpackage

@@ sv/dvr_table.sv @@
// ----------------------------------------------------------------------------
// Distance vector table
// One write port, one registered read port; unwritten entries read as the
// reset infinity through per-entry valid bits.
// ----------------------------------------------------------------------------
module dvr_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dvr_pkg::tbl_wr_t            wr,
    input  logic [dvr_pkg::ADDR_W-1:0]  raddr,
    output logic [dvr_pkg::DIST_W-1:0]  rdata
);
    import dvr_pkg::*;

    logic [DIST_W-1:0]    mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] vld_reg;
    logic [DIST_W-1:0]    q_reg;
    logic                 qv_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            qv_reg <= vld_reg[raddr];
        end
    end

    assign rdata = qv_reg ? q_reg : INF_RESET;

endmodule

@@ sv/distance_vector_router.sv @@
// Recompute: per destination the walk reads the old own entry, then every row,
//   through the single table read port.
// Announcement: each result is read, loaded and held until taken; up to 56 results.
// Throughput: one transaction at a time; input stalls until all results are taken.
// Reset: costs and table read as 1023, config to own_id 0, infinity 1023, no poison.
// ----------------------------------------------------------------------------
// Distance vector router
// Bellman-Ford node: table walk on vector end or cost change, announce on change.
// ----------------------------------------------------------------------------
module distance_vector_router (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dvr_pkg::CFG_W-1:0]   cfg_index,
    input  logic [dvr_pkg::DIST_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  dvr_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output dvr_pkg::out_item_t          out_data
);
    import dvr_pkg::*;

    localparam int J_W = $clog2(NODES + 2);
    localparam int T_W = NODE_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RC,
        S_SCAN,
        S_RD,
        S_LD,
        S_WT
    } state_t;

    state_t            state_reg;
    logic [NODE_W-1:0] own_reg;
    logic [DIST_W-1:0] inf_reg;
    logic              poison_reg;
    logic [DIST_W-1:0] lc_reg [NODES];
    logic [T_W-1:0]    t_reg;
    logic [J_W-1:0]    j_reg;
    logic [NODE_W-1:0] e_reg;
    logic [DIST_W:0]   best_reg;
    logic [DIST_W-1:0] old_reg;
    logic              changed_reg;
    logic              always_ann_reg;
    logic              pz_reg;
    logic [NODE_W-1:0] pidx_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    tbl_wr_t           tbl_wr;
    logic [ADDR_W-1:0] tbl_raddr;
    logic [DIST_W-1:0] tbl_rdata;

    logic              in_acc;
    logic              idx_ok;
    logic              src_ok;
    logic [NODE_W-1:0] cur_t;
    logic [J_W-1:0]    jm1;
    logic [J_W-1:0]    jm2;
    logic [NODE_W-1:0] rc_n;
    logic [DIST_W:0]   sum;
    logic              take;
    logic [DIST_W:0]   best_cand;
    logic [NODES-1:0]  elig;
    logic              later;
    logic              t_done;
    logic              walk_end;

    dvr_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign idx_ok = ({1'b0, in_data.node_index} < T_W'(NODES));
    assign src_ok = ({1'b0, in_data.source_node} < T_W'(NODES));

    assign cur_t    = t_reg[NODE_W-1:0];
    assign t_done   = (t_reg == T_W'(NODES));
    assign jm1      = j_reg - J_W'(1);
    assign jm2      = j_reg - J_W'(2);
    assign rc_n     = jm2[NODE_W-1:0];
    assign walk_end = (j_reg == J_W'(NODES + 1));

    // min-plus step on the row read back this cycle
    assign sum       = {1'b0, lc_reg[rc_n]} + {1'b0, tbl_rdata};
    assign take      = (j_reg >= J_W'(2)) && (rc_n != own_reg) && (sum < best_reg);
    assign best_cand = take ? sum : best_reg;

    always_comb
    begin
        later = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            elig[i] = (NODE_W'(i) != own_reg) && (lc_reg[i] != inf_reg);
            if (T_W'(i) > t_reg)
            begin
                later = later | elig[i];
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_RC:    tbl_raddr = (j_reg == '0) ? {own_reg, cur_t}
                                               : {jm1[NODE_W-1:0], cur_t};
            default: tbl_raddr = {own_reg, e_reg};
        endcase
    end

    always_comb
    begin
        tbl_wr = '0;
        if (in_acc && in_data.cmd == CMD_ELEM && src_ok && idx_ok)
        begin
            tbl_wr = '{en: 1'b1, addr: {in_data.source_node, in_data.node_index},
                       data: in_data.distance_value};
        end
        else if (in_acc && in_data.cmd == CMD_COST_INIT && idx_ok)
        begin
            tbl_wr = '{en: 1'b1, addr: {own_reg, in_data.node_index},
                       data: in_data.distance_value};
        end
        else if (state_reg == S_RC && !t_done && cur_t != own_reg && walk_end)
        begin
            tbl_wr = '{en: 1'b1, addr: {own_reg, cur_t}, data: best_cand[DIST_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            own_reg        <= '0;
            inf_reg        <= INF_RESET;
            poison_reg     <= 1'b0;
            for (int i = 0; i < NODES; i++)
            begin
                lc_reg[i] <= INF_RESET;
            end
            t_reg          <= '0;
            j_reg          <= '0;
            e_reg          <= '0;
            best_reg       <= '0;
            old_reg        <= '0;
            changed_reg    <= 1'b0;
            always_ann_reg <= 1'b0;
            pz_reg         <= 1'b0;
            pidx_reg       <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OWN_ID:   own_reg    <= cfg_data[NODE_W-1:0];
                    CFG_INFINITY: inf_reg    <= cfg_data;
                    CFG_POISON:   poison_reg <= cfg_data[0];
                    default:      ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    t_reg       <= '0;
                    j_reg       <= '0;
                    changed_reg <= 1'b0;
                    if (in_acc)
                    begin
                        unique case (in_data.cmd)
                            CMD_ELEM:
                            begin
                                always_ann_reg <= 1'b0;
                                pz_reg         <= 1'b0;
                                if (in_data.last_element)
                                begin
                                    state_reg <= S_RC;
                                end
                            end
                            CMD_COST_CHG:
                            begin
                                if (idx_ok)
                                begin
                                    lc_reg[in_data.node_index] <= in_data.distance_value;
                                    always_ann_reg <= 1'b1;
                                    pz_reg         <= poison_reg;
                                    pidx_reg       <= in_data.node_index;
                                    state_reg      <= S_RC;
                                end
                            end
                            CMD_COST_INIT:
                            begin
                                if (idx_ok)
                                begin
                                    lc_reg[in_data.node_index] <= in_data.distance_value;
                                end
                            end
                            CMD_ANNOUNCE:
                            begin
                                pz_reg    <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end

                // j = 0 reads the old own entry, j = 1..NODES read rows 0..NODES-1
                S_RC:
                begin
                    if (t_done)
                    begin
                        t_reg     <= '0;
                        state_reg <= (always_ann_reg || changed_reg) ? S_SCAN : S_IDLE;
                    end
                    else if (j_reg == '0 && cur_t == own_reg)
                    begin
                        t_reg <= t_reg + T_W'(1);
                    end
                    else
                    begin
                        if (j_reg == '0)
                        begin
                            best_reg <= {1'b0, inf_reg};
                        end
                        if (j_reg == J_W'(1))
                        begin
                            old_reg <= tbl_rdata;
                        end
                        if (j_reg >= J_W'(2))
                        begin
                            best_reg <= best_cand;
                        end
                        if (walk_end)
                        begin
                            if (best_cand[DIST_W-1:0] != old_reg)
                            begin
                                changed_reg <= 1'b1;
                            end
                            j_reg <= '0;
                            t_reg <= t_reg + T_W'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + J_W'(1);
                        end
                    end
                end

                S_SCAN:
                begin
                    e_reg <= '0;
                    if (t_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (elig[cur_t])
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        t_reg <= t_reg + T_W'(1);
                    end
                end

                S_RD:
                begin
                    state_reg <= S_LD;
                end

                S_LD:
                begin
                    out_reg.dest_router <= cur_t;
                    out_reg.entry_index <= e_reg;
                    out_reg.distance    <= (pz_reg && cur_t != pidx_reg && e_reg == pidx_reg)
                                           ? inf_reg : tbl_rdata;
                    out_reg.packet_end  <= (e_reg == NODE_W'(NODES - 1));
                    out_reg.last        <= (e_reg == NODE_W'(NODES - 1)) && !later;
                    out_valid_reg       <= 1'b1;
                    state_reg           <= S_WT;
                end

                S_WT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (e_reg == NODE_W'(NODES - 1))
                        begin
                            t_reg     <= t_reg + T_W'(1);
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            e_reg     <= e_reg + NODE_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "distance_vector_router_assert.svh"

    `DVR_CHECK(a_out_only_in_wait, !out_valid_reg || state_reg == S_WT)
    `DVR_CHECK_NEXT(a_last_drains, out_valid && !out_stall && out_data.last, !out_valid)
    `DVR_CHECK_NEXT(a_announce_starts, in_acc && in_data.cmd == CMD_ANNOUNCE,
                    state_reg == S_SCAN && t_reg == '0)

endmodule
